FILE: hdl/tlh_pkg.sv
// Shared constants, codes, types and helpers for the latency histogram block.
package tlh_pkg;

  // Field and store sizes
  localparam int TICK_W  = 64;
  localparam int CNT_W   = 32;
  localparam int VB_W    = 7;
  localparam int PER_W   = 24;
  localparam int BUCKETS = 32;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int PROD_W  = TICK_W / 2 + PER_W;
  localparam int SEEN_W  = CNT_W + 2;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_QUERY = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_REC    = 2'd0;
  localparam logic [1:0] ST_UNAV   = 2'd1;
  localparam logic [1:0] ST_QUERY  = 2'd2;
  localparam logic [1:0] ST_CLEARD = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 1'd1;

  // Configuration reset values
  localparam logic [VB_W-1:0]  VB_RESET  = 7'd64;
  localparam logic [PER_W-1:0] PER_RESET = 24'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_LOG,
    S_READ,
    S_UPDATE,
    S_QRD,
    S_QACC,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_ready;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic log_b;
    logic bkt_rd;
    logic bkt_upd;
    logic drop;
    logic clear;
    logic q_init;
    logic q_rd;
    logic q_acc;
    logic res_load;
  } tlh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] func;
    logic       pair_ok;
    logic       count_zero;
    logic       median_hit;
    logic       walk_last;
    logic       out_full;
  } tlh_sts_t;

  // Floor log2 bucket, values below two in bucket 0, clamped to the top bucket
  function automatic logic [BKT_W-1:0] bucket_of(input logic [TICK_W-1:0] ns);
    logic [VB_W-1:0] b;
    b = '0;
    for (int i = 1; i < TICK_W; i++) begin
      if (ns[i]) begin
        b = VB_W'(i);
      end
    end
    if (b > VB_W'(BUCKETS - 1)) begin
      b = VB_W'(BUCKETS - 1);
    end
    return b[BKT_W-1:0];
  endfunction

endpackage

FILE: hdl/tlh_if.sv
// Valid/ready channel interfaces for the request and result sides.
interface tlh_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [tlh_pkg::TICK_W-1:0] start_ticks;
  logic [tlh_pkg::TICK_W-1:0] end_ticks;
  logic                       start_ready;
  logic                       end_ready;

  modport source (output valid, func, start_ticks, end_ticks, start_ready, end_ready,
                  input ready);
  modport sink (input valid, func, start_ticks, end_ticks, start_ready, end_ready,
                output ready);
endinterface

interface tlh_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [tlh_pkg::TICK_W-1:0] duration_ns;
  logic [tlh_pkg::CNT_W-1:0]  samples;
  logic [tlh_pkg::TICK_W-1:0] least_ns;
  logic [tlh_pkg::TICK_W-1:0] greatest_ns;
  logic [tlh_pkg::TICK_W-1:0] sum_ns;
  logic [tlh_pkg::TICK_W-1:0] median_ns;
  logic [tlh_pkg::CNT_W-1:0]  unavailable_pairs;

  modport source (output valid, status, duration_ns, samples, least_ns, greatest_ns,
                  sum_ns, median_ns, unavailable_pairs, input ready);
  modport sink (input valid, status, duration_ns, samples, least_ns, greatest_ns,
                sum_ns, median_ns, unavailable_pairs, output ready);
endinterface

FILE: hdl/timestamp_latency_histogram_top.sv
// Top level of the timestamp latency histogram: controller, datapath and checks.
// Takes one request at a time and returns exactly one result for each. An add
// request is paced by the single 32x24 multiplier used twice per pair and the
// read-modify-write of one bucket in the bucket store; an unavailable pair or a
// clear skips both. A query on a non-empty histogram walks the 32 buckets from
// the lowest up, reading the bucket store one entry at a time, until it reaches
// the median or the last bucket. The result sits in an output register, so a
// finished result can wait on the output while the next request is taken. No
// clearing pass is needed after reset.
module timestamp_latency_histogram_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlh_pkg::PER_W-1:0]     cfg_wdata,
  tlh_in_if.sink                        in_ch,
  tlh_out_if.source                     out_ch
);
  import tlh_pkg::*;

  tlh_cmd_t cmd;
  tlh_sts_t sts;

  tlh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  tlh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One request in flight: no transfer directly after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in flight");

  // Never overwrite a result still waiting on the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.res_load && sts.out_full))
    else $error("result loaded over a waiting result");

  // A recorded sample leaves a non-zero sample count
  a_rec_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status != ST_REC || out_ch.samples != '0))
    else $error("recorded result with zero samples");

  // A query on an empty histogram reports no median
  a_empty_median: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.samples == '0) |-> (out_ch.median_ns == '0))
    else $error("median reported with no samples");

endmodule

FILE: hdl/tlh_ctrl.sv
// Controller state machine sequencing add, query and clear requests.
module tlh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  tlh_pkg::tlh_sts_t sts,
  output tlh_pkg::tlh_cmd_t cmd
);
  import tlh_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        priority if (sts.func == FN_ADD) begin
          if (sts.pair_ok) begin
            state_nxt = S_MUL_LO;
          end else begin
            cmd.drop  = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (sts.func == FN_CLEAR) begin
          cmd.clear = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.q_init = 1'b1;
          state_nxt  = sts.count_zero ? S_DONE : S_QRD;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.log_b = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.bkt_rd = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.bkt_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_QRD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        cmd.q_acc = 1'b1;
        state_nxt = (sts.median_hit || sts.walk_last) ? S_DONE : S_QRD;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!sts.out_full) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/tlh_dp.sv
// Datapath: configuration, scaling, statistics, bucket store and output register.
module tlh_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tlh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlh_pkg::PER_W-1:0]         cfg_wdata,
  tlh_in_if.sink                            in_ch,
  tlh_out_if.source                         out_ch,
  input  tlh_pkg::tlh_cmd_t                 cmd,
  output tlh_pkg::tlh_sts_t                 sts
);
  import tlh_pkg::*;

  // Configuration
  logic [VB_W-1:0]  vb_r;
  logic [PER_W-1:0] period_r;

  // Captured request
  logic [1:0]        func_r;
  logic              pair_ok_r;
  logic [TICK_W-1:0] start_r;
  logic [TICK_W-1:0] end_r;

  // Scaling pipeline
  logic [TICK_W-1:0] ticks_r;
  logic [PROD_W-1:0] prod_lo_r;
  logic [PROD_W-1:0] prod_hi_r;
  logic [TICK_W-1:0] dur_r;
  logic [BKT_W-1:0]  bucket_r;

  // Statistics
  logic [CNT_W-1:0]  count_r;
  logic [TICK_W-1:0] min_r;
  logic [TICK_W-1:0] max_r;
  logic [TICK_W-1:0] sum_r;
  logic [CNT_W-1:0]  dropped_r;

  // Bucket store
  logic [CNT_W-1:0]   bkt_mem [BUCKETS];
  logic [BUCKETS-1:0] bkt_vld_r;
  logic [CNT_W-1:0]   rd_data_r;
  logic               rd_vld_r;
  logic [BKT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   bkt_cnt;
  logic [CNT_W-1:0]   bkt_inc;

  // Median walk
  logic [BKT_W-1:0]  walk_r;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic [SEEN_W-1:0] target_r;
  logic [TICK_W-1:0] median_r;

  // Output register
  logic              out_valid_r;
  logic [1:0]        o_status_r;
  logic [TICK_W-1:0] o_dur_r;
  logic [CNT_W-1:0]  o_samples_r;
  logic [TICK_W-1:0] o_least_r;
  logic [TICK_W-1:0] o_greatest_r;
  logic [TICK_W-1:0] o_sum_r;
  logic [TICK_W-1:0] o_median_r;
  logic [CNT_W-1:0]  o_dropped_r;

  // Combinational helpers
  logic [TICK_W-1:0] tick_mask;
  logic [TICK_W/2-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [TICK_W:0]   scale_sum;
  logic              scale_sat;
  logic [TICK_W:0]   total_sum;
  logic [1:0]        status_code;
  logic              capture;

  assign capture = in_ch.valid && in_ch.ready;
  assign in_ch.ready = cmd.in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r     <= VB_RESET;
      period_r <= PER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_VALID_BITS) begin
        vb_r <= cfg_wdata[VB_W-1:0];
      end else begin
        period_r <= cfg_wdata;
      end
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (capture) begin
      func_r    <= in_ch.func;
      pair_ok_r <= in_ch.start_ready && in_ch.end_ready;
      start_r   <= in_ch.start_ticks;
      end_r     <= in_ch.end_ticks;
    end
  end

  // Tick mask: widths of 64 and above mask nothing
  assign tick_mask = vb_r[VB_W-1] ? '1 : ((TICK_W'(1) << vb_r[VB_W-2:0]) - TICK_W'(1));

  // Shared 32x24 multiplier, low half then high half
  assign mul_a = cmd.mul_hi ? ticks_r[TICK_W-1:TICK_W/2] : ticks_r[TICK_W/2-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(period_r);

  // Recombine: high part shifted by 16, plus low part drop 16 fraction bits
  assign scale_sum = {1'b0, prod_hi_r[TICK_W-17:0], 16'd0}
                   + (TICK_W + 1)'(prod_lo_r[PROD_W-1:16]);
  assign scale_sat = (prod_hi_r[PROD_W-1:TICK_W-16] != '0) || scale_sum[TICK_W];

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      ticks_r <= (end_r - start_r) & tick_mask;
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= mul_p;
    end
    if (cmd.scale) begin
      dur_r <= scale_sat ? '1 : scale_sum[TICK_W-1:0];
    end
    if (cmd.log_b) begin
      bucket_r <= bucket_of(dur_r);
    end
  end

  // Bucket store: one read port, one write port, registered read
  assign rd_addr = cmd.q_rd ? walk_r : bucket_r;
  assign bkt_cnt = rd_vld_r ? rd_data_r : '0;
  assign bkt_inc = (bkt_cnt == '1) ? bkt_cnt : bkt_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.bkt_rd || cmd.q_rd) begin
      rd_data_r <= bkt_mem[rd_addr];
      rd_vld_r  <= bkt_vld_r[rd_addr];
    end
    if (cmd.bkt_upd) begin
      bkt_mem[bucket_r] <= bkt_inc;
    end
  end

  // Entry valid bits: cleared on reset and clear
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      bkt_vld_r <= '0;
    end else if (cmd.bkt_upd) begin
      bkt_vld_r[bucket_r] <= 1'b1;
    end
  end

  // Statistics update
  assign total_sum = {1'b0, sum_r} + {1'b0, dur_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r   <= '0;
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      dropped_r <= '0;
    end else begin
      if (cmd.drop && dropped_r != '1) begin
        dropped_r <= dropped_r + CNT_W'(1);
      end
      if (cmd.bkt_upd) begin
        if (count_r == '0 || dur_r < min_r) begin
          min_r <= dur_r;
        end
        if (count_r == '0 || dur_r > max_r) begin
          max_r <= dur_r;
        end
        if (count_r != '1) begin
          count_r <= count_r + CNT_W'(1);
        end
        sum_r <= total_sum[TICK_W] ? '1 : total_sum[TICK_W-1:0];
      end
    end
  end

  // Median walk: accumulate bucket counts until half the samples are passed
  assign seen_nxt = seen_r + SEEN_W'(bkt_cnt);

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      walk_r   <= '0;
      seen_r   <= '0;
      target_r <= (SEEN_W'(count_r) + SEEN_W'(1)) >> 1;
      median_r <= '0;
    end else if (cmd.q_acc) begin
      seen_r <= seen_nxt;
      priority if (seen_nxt >= target_r) begin
        median_r <= (walk_r == '0) ? '0 : (TICK_W'(1) << walk_r);
      end else if (walk_r == BKT_W'(BUCKETS - 1)) begin
        median_r <= max_r;
      end else begin
        walk_r <= walk_r + BKT_W'(1);
      end
    end
  end

  // Result status from the request kind
  always_comb begin
    priority if (func_r == FN_ADD) begin
      status_code = pair_ok_r ? ST_REC : ST_UNAV;
    end else if (func_r == FN_CLEAR) begin
      status_code = ST_CLEARD;
    end else begin
      status_code = ST_QUERY;
    end
  end

  // Output register: load a result, drop valid on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      o_status_r   <= status_code;
      o_dur_r      <= (status_code == ST_REC) ? dur_r : '0;
      o_samples_r  <= count_r;
      o_least_r    <= (count_r != '0) ? min_r : '0;
      o_greatest_r <= (count_r != '0) ? max_r : '0;
      o_sum_r      <= sum_r;
      o_median_r   <= (status_code == ST_QUERY) ? median_r : '0;
      o_dropped_r  <= dropped_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.duration_ns       = o_dur_r;
  assign out_ch.samples           = o_samples_r;
  assign out_ch.least_ns          = o_least_r;
  assign out_ch.greatest_ns       = o_greatest_r;
  assign out_ch.sum_ns            = o_sum_r;
  assign out_ch.median_ns         = o_median_r;
  assign out_ch.unavailable_pairs = o_dropped_r;

  // Status back to the controller
  assign sts.in_valid   = in_ch.valid;
  assign sts.func       = func_r;
  assign sts.pair_ok    = pair_ok_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.median_hit = (seen_nxt >= target_r);
  assign sts.walk_last  = (walk_r == BKT_W'(BUCKETS - 1));
  assign sts.out_full   = out_valid_r && !out_ch.ready;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the timestamp latency histogram block.
`timescale 1ns / 100ps

module tb;
  import tlh_pkg::*;

  // The spare request code is answered as a query
  localparam logic [1:0] FN_ALIAS_QUERY = 2'd3;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES  = 80;
  localparam int         PHASE_ITEMS    = 370;

  typedef struct packed {
    logic [1:0]        func;
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] end_ticks;
    logic              start_ready;
    logic              end_ready;
  } pair_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TICK_W-1:0] duration_ns;
    logic [CNT_W-1:0]  samples;
    logic [TICK_W-1:0] least_ns;
    logic [TICK_W-1:0] greatest_ns;
    logic [TICK_W-1:0] sum_ns;
    logic [TICK_W-1:0] median_ns;
    logic [CNT_W-1:0]  unavailable_pairs;
  } stat_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PER_W-1:0]     cfg_wdata;

  tlh_in_if  in_ch ();
  tlh_out_if out_ch ();

  timestamp_latency_histogram_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted histogram state and register copies
  logic [VB_W-1:0]   hist_vb;
  logic [PER_W-1:0]  hist_period;
  logic [CNT_W-1:0]  hist_samples;
  logic [TICK_W-1:0] hist_min;
  logic [TICK_W-1:0] hist_max;
  logic [TICK_W-1:0] hist_total;
  logic [CNT_W-1:0]  hist_bkt [BUCKETS];
  logic [CNT_W-1:0]  hist_dropped;

  stat_res_t expected_stats [$];
  int        mismatches;
  int        src_idle_pct;
  int        sink_idle_pct;
  int        hold_requests;
  int        hold_served;
  int        hold_left;
  int        stall_cycles;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [TICK_W-1:0] scale_to_ns(input logic [TICK_W-1:0] ticks);
    logic [TICK_W+PER_W-1:0] prod;
    prod = (TICK_W + PER_W)'(ticks) * (TICK_W + PER_W)'(hist_period);
    // Scaled product must fit in 64 bits after dropping the fraction
    if (prod[TICK_W+PER_W-1:TICK_W+16] != '0) begin
      return '1;
    end
    return prod[TICK_W+15:16];
  endfunction

  function automatic int log2_bucket(input logic [TICK_W-1:0] ns);
    int b;
    logic [TICK_W-1:0] v;
    b = 0;
    v = ns;
    while (v > 1) begin
      v = v >> 1;
      b++;
    end
    if (b > BUCKETS - 1) begin
      b = BUCKETS - 1;
    end
    return b;
  endfunction

  function automatic logic [TICK_W-1:0] median_edge();
    logic [CNT_W+7:0] target;
    logic [CNT_W+7:0] seen;
    if (hist_samples == '0) begin
      return '0;
    end
    target = ((CNT_W + 8)'(hist_samples) + 1) / 2;
    seen = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      seen += (CNT_W + 8)'(hist_bkt[i]);
      if (seen >= target) begin
        return (i == 0) ? '0 : (64'd1 << i);
      end
    end
    // Only reachable once a bucket count has saturated
    return hist_max;
  endfunction

  function automatic void clear_hist();
    hist_samples = '0;
    hist_min     = '0;
    hist_max     = '0;
    hist_total   = '0;
    hist_dropped = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      hist_bkt[i] = '0;
    end
  endfunction

  // Advance the predicted state by one request and queue its expected answer
  function automatic void predict_stats(input pair_req_t r);
    stat_res_t         e;
    logic [TICK_W-1:0] mask;
    logic [TICK_W-1:0] dur;
    logic [TICK_W:0]   sum;
    logic [BKT_W-1:0]  b;
    e = '0;
    case (r.func)
      FN_ADD: begin
        if (!r.start_ready || !r.end_ready) begin
          e.status = ST_UNAV;
          if (hist_dropped != '1) begin
            hist_dropped++;
          end
        end else begin
          mask = (hist_vb >= 64) ? '1 : ((64'd1 << hist_vb) - 64'd1);
          dur = scale_to_ns((r.end_ticks - r.start_ticks) & mask);
          if (hist_samples == '0 || dur < hist_min) begin
            hist_min = dur;
          end
          if (hist_samples == '0 || dur > hist_max) begin
            hist_max = dur;
          end
          if (hist_samples != '1) begin
            hist_samples++;
          end
          sum = {1'b0, hist_total} + {1'b0, dur};
          hist_total = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
          b = BKT_W'(log2_bucket(dur));
          if (hist_bkt[b] != '1) begin
            hist_bkt[b]++;
          end
          e.status = ST_REC;
          e.duration_ns = dur;
        end
      end
      FN_CLEAR: begin
        e.status = ST_CLEARD;
        clear_hist();
      end
      default: begin
        e.status = ST_QUERY;
        e.median_ns = median_edge();
      end
    endcase
    e.samples           = hist_samples;
    e.least_ns          = (hist_samples != '0) ? hist_min : '0;
    e.greatest_ns       = (hist_samples != '0) ? hist_max : '0;
    e.sum_ns            = hist_total;
    e.unavailable_pairs = hist_dropped;
    expected_stats = {expected_stats, e};
  endfunction

  function automatic pair_req_t make_req(input logic [1:0] func,
                                         input logic [TICK_W-1:0] s,
                                         input logic [TICK_W-1:0] e,
                                         input logic sr, input logic er);
    pair_req_t r;
    r.func        = func;
    r.start_ticks = s;
    r.end_ticks   = e;
    r.start_ready = sr;
    r.end_ready   = er;
    return r;
  endfunction

  // Mostly well-formed pairs spread over every bucket, with some noise
  function automatic pair_req_t random_req();
    pair_req_t         r;
    logic [TICK_W-1:0] diff;
    int                width;
    int                pick;
    r.start_ticks = {$urandom, $urandom};
    width = $urandom_range(0, 64);
    diff = {$urandom, $urandom};
    if (width < 64) begin
      diff = diff & ((64'd1 << width) - 64'd1);
    end
    r.end_ticks = ($urandom_range(9) == 0) ? {$urandom, $urandom} : r.start_ticks + diff;
    r.start_ready = ($urandom_range(19) != 0);
    r.end_ready   = ($urandom_range(19) != 0);
    pick = $urandom_range(99);
    if (pick < 86) begin
      r.func = FN_ADD;
    end else if (pick < 96) begin
      r.func = FN_QUERY;
    end else if (pick < 98) begin
      r.func = FN_ALIAS_QUERY;
    end else begin
      r.func = FN_CLEAR;
    end
    return r;
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_req(input pair_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= r.func;
    in_ch.start_ticks <= r.start_ticks;
    in_ch.end_ticks   <= r.end_ticks;
    in_ch.start_ready <= r.start_ready;
    in_ch.end_ready   <= r.end_ready;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predict_stats(r);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PER_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VALID_BITS) begin
      hist_vb = data[VB_W-1:0];
    end else begin
      hist_period = data;
    end
  endtask

  task automatic test_empty_query();
    send_req(make_req(FN_QUERY, '1, '1, 1'b1, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_req(make_req(FN_ADD, '0, '0, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, '1, '0, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, '0, '1, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, 64'd5, 64'd8, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, 64'd0, 64'd2, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, '1, '1, 1'b0, 1'b1));
    send_req(make_req(FN_ADD, '1, '1, 1'b1, 1'b0));
    send_req(make_req(FN_ADD, '0, '0, 1'b0, 1'b0));
    // Second maximal pair pushes the total into saturation
    send_req(make_req(FN_ADD, 64'd1, 64'd0, 1'b1, 1'b1));
    send_req(make_req(FN_QUERY, '0, '0, 1'b0, 1'b0));
    send_req(make_req(FN_ALIAS_QUERY, '1, '0, 1'b1, 1'b0));
    send_req(make_req(FN_CLEAR, '1, '1, 1'b1, 1'b1));
    send_req(make_req(FN_QUERY, '1, '1, 1'b1, 1'b1));
  endtask

  task automatic test_config_extremes();
    // Zero counter width records only zero durations
    drain();
    cfg_write(CFG_VALID_BITS, 24'd0);
    send_req(make_req(FN_ADD, 64'h1234, 64'hFFFF_0000_0000_1234, 1'b1, 1'b1));
    drain();
    cfg_write(CFG_VALID_BITS, 24'd127);
    send_req(make_req(FN_ADD, 64'h10, 64'h8000_0000_0000_0010, 1'b1, 1'b1));
    drain();
    cfg_write(CFG_VALID_BITS, 24'd1);
    send_req(make_req(FN_ADD, 64'd0, 64'd3, 1'b1, 1'b1));
    // Zero period records only zero durations
    drain();
    cfg_write(CFG_VALID_BITS, 24'd64);
    cfg_write(CFG_PERIOD, 24'd0);
    send_req(make_req(FN_ADD, 64'd0, 64'hFFFF, 1'b1, 1'b1));
    drain();
    cfg_write(CFG_PERIOD, 24'hFF_FFFF);
    send_req(make_req(FN_ADD, 64'd0, 64'h0100_0000_0000_0000, 1'b1, 1'b1));
    send_req(make_req(FN_ADD, 64'd7, 64'd9, 1'b1, 1'b1));
    send_req(make_req(FN_QUERY, '0, '0, 1'b0, 1'b0));
    drain();
    cfg_write(CFG_PERIOD, 24'd1);
    send_req(make_req(FN_ADD, 64'd0, 64'h3_0000, 1'b1, 1'b1));
    send_req(make_req(FN_QUERY, '0, '0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic();
    int vb;
    int per;
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      src_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 63 : 0;
      sink_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 23 : 0;
      vb  = ($urandom_range(2) == 0) ? 64 : $urandom_range(1, 64);
      case ($urandom_range(2))
        0:       per = 65536;
        1:       per = $urandom_range(1, 24'h3_FFFF);
        default: per = $urandom_range(1, 24'hFF_FFFF);
      endcase
      cfg_write(CFG_VALID_BITS, PER_W'(vb));
      cfg_write(CFG_PERIOD, PER_W'(per));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_req(random_req());
      end
    end
  endtask

  // Hold the result side off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    drain();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_requests++;
    for (int n = 0; n < 12; n++) begin
      send_req(random_req());
    end
  endtask

  // Pause the request side until every result is back, then resume
  task automatic test_request_pause();
    src_idle_pct  = 23;
    sink_idle_pct = 63;
    for (int n = 0; n < 6; n++) begin
      send_req(random_req());
    end
    drain();
    for (int n = 0; n < 6; n++) begin
      send_req(random_req());
    end
  endtask

  // Result side ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [TICK_W-1:0] want,
                                      input logic [TICK_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    stat_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result with nothing expected, status %0d", out_ch.status);
        mismatches++;
      end else begin
        want = expected_stats.pop_front();
        check_field("status", TICK_W'(want.status), TICK_W'(out_ch.status));
        check_field("duration_ns", want.duration_ns, out_ch.duration_ns);
        check_field("samples", TICK_W'(want.samples), TICK_W'(out_ch.samples));
        check_field("least_ns", want.least_ns, out_ch.least_ns);
        check_field("greatest_ns", want.greatest_ns, out_ch.greatest_ns);
        check_field("sum_ns", want.sum_ns, out_ch.sum_ns);
        check_field("median_ns", want.median_ns, out_ch.median_ns);
        check_field("unavailable_pairs", TICK_W'(want.unavailable_pairs),
                    TICK_W'(out_ch.unavailable_pairs));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_VALID_BITS;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_ADD;
    in_ch.start_ticks = '0;
    in_ch.end_ticks   = '0;
    in_ch.start_ready = 1'b0;
    in_ch.end_ready   = 1'b0;
    out_ch.ready      = 1'b0;
    mismatches        = 0;
    src_idle_pct      = 23;
    sink_idle_pct     = 63;
    hold_requests     = 0;
    hold_served       = 0;
    hold_left         = 0;
    stall_cycles      = 0;
    hist_vb           = VB_RESET;
    hist_period       = PER_RESET;
    clear_hist();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_query();
    test_field_extremes();
    test_config_extremes();
    test_result_backpressure();
    test_request_pause();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: timestamp_latency_histogram_top.f
hdl/tlh_pkg.sv
hdl/tlh_if.sv
hdl/tlh_ctrl.sv
hdl/tlh_dp.sv
hdl/timestamp_latency_histogram_top.sv
tb/tb.sv
